[sv/nit_pkg.sv]
// Shared types and constants for the NEC infrared transmitter.
package nit_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int DATA_BITS      = 32;
  localparam int COUNT_BITS     = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic        INVERT_RESET       = 1'b1;
  localparam logic [15:0] HALF_PERIOD_RESET  = 16'd13;
  localparam logic [15:0] HDR_MARK_RESET     = 16'd9000;
  localparam logic [15:0] HDR_SPACE_RESET    = 16'd4500;
  localparam logic [15:0] BIT_MARK_RESET     = 16'd560;
  localparam logic [15:0] ONE_SPACE_RESET    = 16'd1690;
  localparam logic [15:0] ZERO_SPACE_RESET   = 16'd560;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INVERT,
    REG_HALF_PERIOD,
    REG_HDR_MARK,
    REG_HDR_SPACE,
    REG_BIT_MARK,
    REG_ONE_SPACE,
    REG_ZERO_SPACE
  } nit_reg_t;

  typedef enum logic {
    REQ_TICK,
    REQ_SEND
  } nit_req_t;

  typedef struct packed {
    logic        invert_level;
    logic [15:0] carrier_half_period;
    logic [15:0] header_mark_ticks;
    logic [15:0] header_space_ticks;
    logic [15:0] bit_mark_ticks;
    logic [15:0] one_space_ticks;
    logic [15:0] zero_space_ticks;
  } nit_cfg_t;

endpackage

[sv/nec_ir_transmitter.sv]
// Top level of the NEC infrared transmitter.
// Each input item is either one timer tick or a send request, and each gives exactly one
// result item with the pin level, the busy flag and a done flag. A tick item is taken every
// cycle while results are taken and no empty phase is being skipped; with the queue empty,
// it is first written into a queue entry and its result is then registered in the output
// register. A two-entry queue separates input acceptance from the frame engine, so up to
// two items are held there while a result waits to be taken; beyond that the input stalls.
// Where phases of length zero are skipped, the frame engine skips each one in a step of its
// own, taking no new item meanwhile, before the item's result is produced.
module nec_ir_transmitter #(
  parameter int DATA_WIDTH = nit_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [nit_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [nit_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic [nit_pkg::DATA_BITS-1:0]        data,
  input  logic [nit_pkg::COUNT_BITS-1:0]       bit_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 ir_out,
  output logic                                 busy_res,
  output logic                                 done_res
);
  import nit_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam int EW = 1 + DATA_WIDTH + CW;

  nit_cfg_t              cfg;
  nit_req_t              f_kind;
  logic [DATA_WIDTH-1:0] f_word;
  logic [CW-1:0]         f_count;
  logic                  q_ready;
  logic                  q_valid;
  logic                  q_pop;
  logic [EW-1:0]         q_data;
  nit_req_t              q_kind;

  assign in_stall = !q_ready;
  assign q_kind   = nit_req_t'(q_data[EW-1]);

  nit_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nit_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .req_type   (req_type),
    .data       (data),
    .bit_count  (bit_count),
    .item_kind  (f_kind),
    .item_word  (f_word),
    .item_count (f_count)
  );

  nit_queue #(.WIDTH(EW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (q_ready),
    .push_data  ({f_kind, f_word, f_count}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  nit_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .item_kind  (q_kind),
    .item_word  (q_data[EW-2:CW]),
    .item_count (q_data[CW-1:0]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ir_out     (ir_out),
    .busy_res   (busy_res),
    .done_res   (done_res)
  );

endmodule

[sv/nit_cfg.sv]
// Configuration register bank of the NEC infrared transmitter.
module nit_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [nit_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [nit_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output nit_pkg::nit_cfg_t                    cfg
);
  import nit_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_level        <= INVERT_RESET;
      cfg.carrier_half_period <= HALF_PERIOD_RESET;
      cfg.header_mark_ticks   <= HDR_MARK_RESET;
      cfg.header_space_ticks  <= HDR_SPACE_RESET;
      cfg.bit_mark_ticks      <= BIT_MARK_RESET;
      cfg.one_space_ticks     <= ONE_SPACE_RESET;
      cfg.zero_space_ticks    <= ZERO_SPACE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INVERT:      cfg.invert_level        <= cfg_data[0];
        REG_HALF_PERIOD: cfg.carrier_half_period <= cfg_data;
        REG_HDR_MARK:    cfg.header_mark_ticks   <= cfg_data;
        REG_HDR_SPACE:   cfg.header_space_ticks  <= cfg_data;
        REG_BIT_MARK:    cfg.bit_mark_ticks      <= cfg_data;
        REG_ONE_SPACE:   cfg.one_space_ticks     <= cfg_data;
        REG_ZERO_SPACE:  cfg.zero_space_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/nit_front.sv]
// Front end: classifies each input item and normalizes its payload.
module nit_front #(
  parameter int DATA_WIDTH = nit_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 req_type,
  input  logic [nit_pkg::DATA_BITS-1:0]        data,
  input  logic [nit_pkg::COUNT_BITS-1:0]       bit_count,
  output nit_pkg::nit_req_t                    item_kind,
  output logic [DATA_WIDTH-1:0]                item_word,
  output logic [$clog2(DATA_WIDTH+1)-1:0]      item_count
);
  import nit_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  always_comb begin
    item_kind = req_type ? REQ_SEND : REQ_TICK;
    item_word = DATA_WIDTH'(data);
    if (int'(bit_count) > DATA_WIDTH) begin
      item_count = CW'(DATA_WIDTH);
    end else begin
      item_count = CW'(bit_count);
    end
  end

endmodule

[sv/nit_queue.sv]
// Two-entry item queue between the front end and the frame engine.
module nit_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  import nit_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[sv/nit_back.sv]
// Frame engine: phase sequencing, carrier generation and the result register.
module nit_back #(
  parameter int DATA_WIDTH = nit_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nit_pkg::nit_cfg_t                    cfg,
  input  logic                                 item_valid,
  output logic                                 item_pop,
  input  nit_pkg::nit_req_t                    item_kind,
  input  logic [DATA_WIDTH-1:0]                item_word,
  input  logic [$clog2(DATA_WIDTH+1)-1:0]      item_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 ir_out,
  output logic                                 busy_res,
  output logic                                 done_res
);
  import nit_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_TRAIL_MARK
  } phase_t;

  typedef struct packed {
    phase_t                p;
    logic [DATA_WIDTH-1:0] w;
    logic [CW-1:0]         n;
  } step_t;

  function automatic logic is_mark(phase_t p);
    return (p == PH_HDR_MARK) || (p == PH_BIT_MARK) || (p == PH_TRAIL_MARK);
  endfunction

  function automatic logic [15:0] phase_len(phase_t p, logic top, nit_cfg_t c);
    logic [15:0] len;
    case (p)
      PH_HDR_MARK:   len = c.header_mark_ticks;
      PH_HDR_SPACE:  len = c.header_space_ticks;
      PH_BIT_MARK:   len = c.bit_mark_ticks;
      PH_TRAIL_MARK: len = c.bit_mark_ticks;
      PH_BIT_SPACE:  len = top ? c.one_space_ticks : c.zero_space_ticks;
      default:       len = 16'd0;
    endcase
    return len;
  endfunction

  function automatic step_t follow(step_t s);
    step_t r;
    r = s;
    case (s.p)
      PH_HDR_MARK:  r.p = PH_HDR_SPACE;
      PH_HDR_SPACE: r.p = (s.n != '0) ? PH_BIT_MARK : PH_TRAIL_MARK;
      PH_BIT_MARK:  r.p = PH_BIT_SPACE;
      PH_BIT_SPACE: begin
        r.w = s.w << 1;
        r.n = (s.n != '0) ? (s.n - CW'(1)) : s.n;
        r.p = (r.n != '0) ? PH_BIT_MARK : PH_TRAIL_MARK;
      end
      default:      r.p = PH_IDLE;
    endcase
    return r;
  endfunction

  phase_t                phase, phase_next;
  logic [15:0]           dur, dur_next;
  logic [15:0]           car, car_next;
  logic [DATA_WIDTH-1:0] shift, shift_next;
  logic [CW-1:0]         bits, bits_next;
  logic                  pin, pin_next;
  logic                  walk, walk_next;

  logic        out_free;
  logic        emit;
  logic        done;
  logic        do_enter;
  step_t       cur;
  step_t       src;
  step_t       nxt;
  logic [15:0] dur_dec;
  logic [15:0] half;
  logic [16:0] car_sum;
  logic [15:0] len;

  always_comb begin
    phase_next = phase;
    dur_next   = dur;
    car_next   = car;
    shift_next = shift;
    bits_next  = bits;
    pin_next   = pin;
    walk_next  = walk;
    emit       = 1'b0;
    done       = 1'b0;
    do_enter   = 1'b0;
    item_pop   = 1'b0;
    out_free   = !out_valid || !out_stall;
    cur        = '{p: phase, w: shift, n: bits};
    src        = cur;
    nxt        = cur;
    dur_dec    = (dur != 16'd0) ? (dur - 16'd1) : dur;
    half       = (cfg.carrier_half_period == 16'd0) ? 16'd1 : cfg.carrier_half_period;
    car_sum    = {1'b0, car} + 17'd1;
    len        = 16'd0;

    if (out_free) begin
      if (walk) begin
        do_enter = 1'b1;
      end else if (item_valid) begin
        item_pop = 1'b1;
        if (item_kind == REQ_SEND) begin
          if (phase == PH_IDLE) begin
            do_enter = 1'b1;
            src      = '{p: PH_HDR_MARK, w: item_word, n: item_count};
          end else begin
            emit = 1'b1;
          end
        end else if (phase == PH_IDLE) begin
          emit = 1'b1;
        end else if (dur_dec == 16'd0) begin
          do_enter = 1'b1;
          src      = follow(cur);
        end else begin
          dur_next = dur_dec;
          emit     = 1'b1;
          if (pin || is_mark(phase)) begin
            if (car_sum >= {1'b0, half}) begin
              car_next = 16'd0;
              pin_next = ~pin;
            end else begin
              car_next = car_sum[15:0];
            end
          end
        end
      end

      if (do_enter) begin
        car_next   = 16'd0;
        shift_next = src.w;
        bits_next  = src.n;
        if (src.p == PH_IDLE) begin
          phase_next = PH_IDLE;
          dur_next   = 16'd0;
          pin_next   = 1'b0;
          done       = 1'b1;
          emit       = 1'b1;
          walk_next  = 1'b0;
        end else begin
          pin_next = is_mark(src.p);
          len      = phase_len(src.p, src.w[DATA_WIDTH-1], cfg);
          if (len != 16'd0) begin
            phase_next = src.p;
            dur_next   = len;
            emit       = 1'b1;
            walk_next  = 1'b0;
          end else begin
            nxt        = follow(src);
            phase_next = nxt.p;
            shift_next = nxt.w;
            bits_next  = nxt.n;
            walk_next  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      dur       <= 16'd0;
      car       <= 16'd0;
      shift     <= '0;
      bits      <= '0;
      pin       <= 1'b0;
      walk      <= 1'b0;
      out_valid <= 1'b0;
      ir_out    <= 1'b0;
      busy_res  <= 1'b0;
      done_res  <= 1'b0;
    end else begin
      phase <= phase_next;
      dur   <= dur_next;
      car   <= car_next;
      shift <= shift_next;
      bits  <= bits_next;
      pin   <= pin_next;
      walk  <= walk_next;
      if (out_free) begin
        out_valid <= emit;
        ir_out    <= pin_next ^ cfg.invert_level;
        busy_res  <= (phase_next != PH_IDLE);
        done_res  <= done;
      end
    end
  end

endmodule
